/* sv/itp_pkg.sv */
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, codes and constants of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_TIMES = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_CARET = 8'h5e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_OPEN  = 3'd1,
    OP_PLUS  = 3'd2,
    OP_MINUS = 3'd3,
    OP_TIMES = 3'd4,
    OP_DIV   = 3'd5,
    OP_CARET = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_LOW,
    CLS_HIGH,
    CLS_POW,
    CLS_OTHER
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM,
    ST_POP_SYM,
    ST_POP_END,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic pop;
    logic push;
    logic close;
    logic rearm;
    logic emit_sym;
    logic finish;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic end_flag;
    logic pop_sym;
    logic pop_end;
    logic emit_ok;
    logic out_free;
  } sts_t;

  function automatic cls_e sym_class(logic [7:0] sym);
    cls_e c;
    case (sym)
      CH_NUL:            c = CLS_NUL;
      CH_OPEN:           c = CLS_OPEN;
      CH_CLOSE:          c = CLS_CLOSE;
      CH_PLUS, CH_MINUS: c = CLS_LOW;
      CH_TIMES, CH_DIV:  c = CLS_HIGH;
      CH_CARET:          c = CLS_POW;
      default:           c = CLS_OTHER;
    endcase
    return c;
  endfunction

  function automatic op_e sym_op(logic [7:0] sym);
    op_e o;
    case (sym)
      CH_OPEN:  o = OP_OPEN;
      CH_PLUS:  o = OP_PLUS;
      CH_MINUS: o = OP_MINUS;
      CH_TIMES: o = OP_TIMES;
      CH_DIV:   o = OP_DIV;
      CH_CARET: o = OP_CARET;
      default:  o = OP_NONE;
    endcase
    return o;
  endfunction

  function automatic logic [7:0] op_char(op_e op);
    logic [7:0] ch;
    case (op)
      OP_OPEN:  ch = CH_OPEN;
      OP_PLUS:  ch = CH_PLUS;
      OP_MINUS: ch = CH_MINUS;
      OP_TIMES: ch = CH_TIMES;
      OP_DIV:   ch = CH_DIV;
      OP_CARET: ch = CH_CARET;
      default:  ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

/* sv/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard conversion of an infix character stream to postfix order
// ----------------------------------------------------------------------------
// One character is taken per input transfer and handled to completion before
// the next is accepted. A character passes through accept, symbol handling, a
// pop scan for an operator or close parenthesis, a flush scan when tlast is
// set, and finish; each scan pops operators from the stack, and output
// backpressure can stall the handling. The pop rate of one operator per cycle
// while the output is not stalled is set by the stack memory, whose registered
// read port always presents the current top of stack. Results leave one per
// cycle through an output register unless the output stalls; tlast marks the
// final result of each character, and a marker result with tuser low carries
// the flags when no character is emitted but the expression ends or has an error.
module infix_to_postfix_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // symbol
  input  logic        s_axis_tlast_i,  // end_of_expression
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // out_symbol, expression_done, error_code, zeros
  output logic        m_axis_tuser_o,  // has_symbol
  output logic        m_axis_tlast_o   // last_of_run
);
  import itp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cmd_o           (cmd),
    .sts_i           (sts)
  );

  itp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* sv/itp_ctrl.sv */
// ----------------------------------------------------------------------------
// itp_ctrl
// sequencing state machine: accept, symbol handling, pops, flush, finish
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  output itp_pkg::cmd_t cmd_o,
  input  itp_pkg::sts_t sts_i
);
  import itp_pkg::*;

  state_e state_q, state_d;
  state_e after_sym;

  assign after_sym = sts_i.end_flag ? ST_POP_END : ST_FINISH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_SYM;
      end
      ST_SYM: begin
        case (sts_i.cls)
          CLS_NUL, CLS_OPEN: state_d = after_sym;
          CLS_OTHER: begin
            if (sts_i.emit_ok) state_d = after_sym;
          end
          default: state_d = ST_POP_SYM;
        endcase
      end
      ST_POP_SYM: begin
        if (!sts_i.pop_sym) state_d = after_sym;
      end
      ST_POP_END: begin
        if (!sts_i.pop_end) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      ST_SYM: begin
        case (sts_i.cls)
          CLS_OPEN:  cmd_o.push = 1'b1;
          CLS_OTHER: cmd_o.emit_sym = sts_i.emit_ok;
          default:   cmd_o = '0;
        endcase
      end
      ST_POP_SYM: begin
        if (sts_i.pop_sym) begin
          cmd_o.pop = sts_i.emit_ok;
        end else if (sts_i.cls == CLS_CLOSE) begin
          cmd_o.close = 1'b1;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      ST_POP_END: begin
        if (sts_i.pop_end) begin
          cmd_o.pop = sts_i.emit_ok;
        end else begin
          cmd_o.close = 1'b1;
          cmd_o.rearm = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* sv/itp_datapath.sv */
// ----------------------------------------------------------------------------
// itp_datapath
// operator stack memory, counters, pending result and output register
// ----------------------------------------------------------------------------
module itp_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itp_pkg::cmd_t cmd_i,
  output itp_pkg::sts_t sts_o,
  input  logic [7:0]    s_axis_tdata_i,  // symbol
  input  logic          s_axis_tlast_i,  // end_of_expression
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [15:0]   m_axis_tdata_o,  // out_symbol, expression_done, error_code, zeros
  output logic          m_axis_tuser_o,  // has_symbol
  output logic          m_axis_tlast_o   // last_of_run
);
  import itp_pkg::*;

  op_e               mem [STACK_DEPTH];
  op_e               rd_q;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CNT_W-1:0]  cnt_dec;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              sent_q, sent_d;
  err_e              err_q, err_d;
  logic [7:0]        sym_q;
  logic              end_q;
  cls_e              cls;

  logic              pend_valid_q, pend_valid_d;
  logic [7:0]        pend_sym_q, pend_sym_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_sym_q, out_sym_d;
  logic              out_has_q, out_has_d;
  logic              out_last_q, out_last_d;
  logic              out_done_q, out_done_d;
  err_e              out_err_q, out_err_d;

  logic              out_free, stack_empty, stop_sym, emit_new;
  logic [7:0]        new_sym;

  assign cls         = sym_class(sym_q);
  assign stack_empty = (count_q == '0);
  assign out_free    = !out_valid_q || m_axis_tready_i;

  always_comb begin
    case (cls)
      CLS_HIGH: stop_sym = (rd_q == OP_OPEN) || (rd_q == OP_PLUS) || (rd_q == OP_MINUS);
      CLS_POW:  stop_sym = (rd_q != OP_CARET);
      default:  stop_sym = (rd_q == OP_OPEN);
    endcase
  end

  assign sts_o.cls      = cls;
  assign sts_o.end_flag = end_q;
  assign sts_o.pop_sym  = !stack_empty && !stop_sym;
  assign sts_o.pop_end  = !stack_empty && (rd_q != OP_OPEN);
  assign sts_o.emit_ok  = !pend_valid_q || out_free;
  assign sts_o.out_free = out_free;

  // stack bookkeeping
  always_comb begin
    count_d = count_q;
    sent_d  = sent_q;
    err_d   = err_q;
    we      = 1'b0;
    waddr   = count_q[ADDR_W-1:0];
    if (cmd_i.load) begin
      err_d = ERR_NONE;
    end
    if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
    if (cmd_i.push) begin
      if (count_q == CNT_W'(STACK_DEPTH)) begin
        if (err_d == ERR_NONE) err_d = ERR_OVERFLOW;
      end else begin
        we      = 1'b1;
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.close) begin
      if (!stack_empty) begin
        count_d = count_q - CNT_W'(1);
      end else if (sent_q) begin
        sent_d = 1'b0;
      end else if (err_d == ERR_NONE) begin
        err_d = ERR_UNMATCHED;
      end
    end
    if (cmd_i.rearm) begin
      count_d = '0;
      sent_d  = 1'b1;
    end
  end

  // top of stack follows the next count
  assign cnt_dec = count_d - CNT_W'(1);
  assign raddr   = cnt_dec[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= sym_op(sym_q);
    end
    if (we && (waddr == raddr)) begin
      rd_q <= sym_op(sym_q);
    end else begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q <= s_axis_tdata_i;
      end_q <= s_axis_tlast_i;
    end
  end

  // results are held one deep so the final one can carry the flags
  assign emit_new = cmd_i.pop || cmd_i.emit_sym;
  assign new_sym  = cmd_i.pop ? op_char(rd_q) : sym_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_sym_d    = out_sym_q;
    out_has_d    = out_has_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;
    out_err_d    = out_err_q;
    if (emit_new) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_has_d   = 1'b1;
        out_last_d  = 1'b0;
        out_done_d  = 1'b0;
        out_err_d   = ERR_NONE;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = new_sym;
    end
    if (cmd_i.finish) begin
      if (pend_valid_q || end_q || (err_q != ERR_NONE)) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_valid_q ? pend_sym_q : CH_NUL;
        out_has_d   = pend_valid_q;
        out_last_d  = 1'b1;
        out_done_d  = end_q;
        out_err_d   = err_q;
      end
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sent_q       <= 1'b1;
      err_q        <= ERR_NONE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      sent_q       <= sent_d;
      err_q        <= err_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
    out_err_q  <= out_err_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_err_q, out_done_q, out_sym_q};
  assign m_axis_tuser_o  = out_has_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stack_empty)
    else $error("pop from empty stack");

  a_load_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !pend_valid_q)
    else $error("pending result left over from previous symbol");

  a_finish_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> !pend_valid_q)
    else $error("pending result not drained at finish");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q != 2'd3)
    else $error("illegal error code");
`endif

endmodule
